[rtl/segment_intersection_assert.svh]
// ---------------------------------------------------------------------------
// Segment intersection assertion macros
// Concurrent checks used by the segment intersection block; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define SEGINT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle
`define SEGINT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SEGINT_ASSERT(lbl, prop, msg)
`define SEGINT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/segint_pkg.sv]
// ---------------------------------------------------------------------------
// Segment intersection package
// Widths, transaction types and the result kind shared by the pipeline.
// ---------------------------------------------------------------------------
package segint_pkg;

	// Coordinate width of every endpoint field
	localparam int unsigned COORD_WIDTH   = 16;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned OUT_WIDTH     = 32;

	// Coordinate difference, product, determinant and magnitude widths
	localparam int unsigned DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int unsigned PROD_WIDTH = 2 * COORD_WIDTH + 1;
	localparam int unsigned DET_WIDTH  = 2 * COORD_WIDTH + 2;
	localparam int unsigned MAG_WIDTH  = 2 * COORD_WIDTH + 1;
	// Product of a delta magnitude and the t numerator
	localparam int unsigned NUMP_WIDTH = COORD_WIDTH + MAG_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t first_start_x;
		coord_t first_start_y;
		coord_t first_end_x;
		coord_t first_end_y;
		coord_t second_start_x;
		coord_t second_start_y;
		coord_t second_end_x;
		coord_t second_end_y;
	} seg_t;

	typedef struct packed {
		logic                        hit;
		logic signed [OUT_WIDTH-1:0] cross_x;
		logic signed [OUT_WIDTH-1:0] cross_y;
	} result_t;

	// How the result point is formed
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_FIRST_START,
		KIND_FIRST_END,
		KIND_CROSS
	} kind_t;

	// Sideband that travels with each transaction down the pipeline
	typedef struct packed {
		kind_t                  kind;
		logic                   ep_start;
		logic                   ep_end;
		logic                   sub_x;
		logic                   sub_y;
		logic [COORD_WIDTH-1:0] mag_x;
		logic [COORD_WIDTH-1:0] mag_y;
		coord_t                 x1;
		coord_t                 y1;
		coord_t                 x2;
		coord_t                 y2;
	} side_t;

endpackage

[rtl/segint_det.sv]
// ---------------------------------------------------------------------------
// Segment intersection determinant stages
// Stages 1 to 3: coordinate differences and endpoint matches, the six
// products, then the den, t and u determinants.
// ---------------------------------------------------------------------------
module segint_det (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    adv,
	input  logic                                    seg_valid,
	input  segint_pkg::seg_t                        seg,
	output logic                                    det_valid,
	output segint_pkg::side_t                       det_side,
	output logic signed [segint_pkg::DET_WIDTH-1:0] det_den,
	output logic signed [segint_pkg::DET_WIDTH-1:0] det_tn,
	output logic signed [segint_pkg::DET_WIDTH-1:0] det_un
);
	import segint_pkg::*;

	logic                         valid_s1, valid_s2, valid_s3;
	side_t                        side_c, side_s1, side_s2, side_s3;
	logic signed [DIFF_WIDTH-1:0] d12x_c, d34x_c, d12y_c, d34y_c, d13x_c, d13y_c;
	logic signed [DIFF_WIDTH-1:0] d12x_s1, d34x_s1, d12y_s1, d34y_s1, d13x_s1, d13y_s1;
	logic signed [DIFF_WIDTH-1:0] absx_c, absy_c;
	logic signed [PROD_WIDTH-1:0] p_ad_s2, p_bc_s2, p_ed_s2, p_bf_s2, p_ec_s2, p_af_s2;
	logic signed [DET_WIDTH-1:0]  den_s3, tn_s3, un_s3;

	// Form differences, delta magnitudes and endpoint matches
	always_comb begin
		d12x_c = DIFF_WIDTH'(seg.first_start_x) - DIFF_WIDTH'(seg.first_end_x);
		d12y_c = DIFF_WIDTH'(seg.first_start_y) - DIFF_WIDTH'(seg.first_end_y);
		d34x_c = DIFF_WIDTH'(seg.second_start_x) - DIFF_WIDTH'(seg.second_end_x);
		d34y_c = DIFF_WIDTH'(seg.second_start_y) - DIFF_WIDTH'(seg.second_end_y);
		d13x_c = DIFF_WIDTH'(seg.first_start_x) - DIFF_WIDTH'(seg.second_start_x);
		d13y_c = DIFF_WIDTH'(seg.first_start_y) - DIFF_WIDTH'(seg.second_start_y);
		absx_c = d12x_c[DIFF_WIDTH-1] ? -d12x_c : d12x_c;
		absy_c = d12y_c[DIFF_WIDTH-1] ? -d12y_c : d12y_c;

		side_c.kind     = KIND_NONE;
		side_c.ep_start =
			(seg.first_start_x == seg.second_start_x &&
			 seg.first_start_y == seg.second_start_y) ||
			(seg.first_start_x == seg.second_end_x &&
			 seg.first_start_y == seg.second_end_y);
		side_c.ep_end =
			(seg.first_end_x == seg.second_start_x &&
			 seg.first_end_y == seg.second_start_y) ||
			(seg.first_end_x == seg.second_end_x &&
			 seg.first_end_y == seg.second_end_y);
		// delta = end - start is negative when start - end is positive
		side_c.sub_x = !d12x_c[DIFF_WIDTH-1] && (d12x_c != '0);
		side_c.sub_y = !d12y_c[DIFF_WIDTH-1] && (d12y_c != '0);
		side_c.mag_x = absx_c[COORD_WIDTH-1:0];
		side_c.mag_y = absy_c[COORD_WIDTH-1:0];
		side_c.x1    = seg.first_start_x;
		side_c.y1    = seg.first_start_y;
		side_c.x2    = seg.first_end_x;
		side_c.y2    = seg.first_end_y;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= seg_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: differences; stage 2: products; stage 3: determinants
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_c;
			d12x_s1 <= d12x_c;
			d34x_s1 <= d34x_c;
			d12y_s1 <= d12y_c;
			d34y_s1 <= d34y_c;
			d13x_s1 <= d13x_c;
			d13y_s1 <= d13y_c;

			side_s2 <= side_s1;
			p_ad_s2 <= PROD_WIDTH'(d12x_s1) * PROD_WIDTH'(d34y_s1);
			p_bc_s2 <= PROD_WIDTH'(d34x_s1) * PROD_WIDTH'(d12y_s1);
			p_ed_s2 <= PROD_WIDTH'(d13x_s1) * PROD_WIDTH'(d34y_s1);
			p_bf_s2 <= PROD_WIDTH'(d34x_s1) * PROD_WIDTH'(d13y_s1);
			p_ec_s2 <= PROD_WIDTH'(d13x_s1) * PROD_WIDTH'(d12y_s1);
			p_af_s2 <= PROD_WIDTH'(d12x_s1) * PROD_WIDTH'(d13y_s1);

			side_s3 <= side_s2;
			den_s3  <= DET_WIDTH'(p_ad_s2) - DET_WIDTH'(p_bc_s2);
			tn_s3   <= DET_WIDTH'(p_ed_s2) - DET_WIDTH'(p_bf_s2);
			un_s3   <= DET_WIDTH'(p_ec_s2) - DET_WIDTH'(p_af_s2);
		end
	end

	assign det_valid = valid_s3;
	assign det_side  = side_s3;
	assign det_den   = den_s3;
	assign det_tn    = tn_s3;
	assign det_un    = un_s3;

endmodule

[rtl/segint_scale.sv]
// ---------------------------------------------------------------------------
// Segment intersection range test and numerator stages
// Stages 4 to 6: sign normalize, range test and result kind, then the
// delta times t numerator products split in two halves.
// ---------------------------------------------------------------------------
module segint_scale (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic                                     det_valid,
	input  segint_pkg::side_t                        det_side,
	input  logic signed [segint_pkg::DET_WIDTH-1:0]  det_den,
	input  logic signed [segint_pkg::DET_WIDTH-1:0]  det_tn,
	input  logic signed [segint_pkg::DET_WIDTH-1:0]  det_un,
	output logic                                     num_valid,
	output segint_pkg::side_t                        num_side,
	output logic [segint_pkg::MAG_WIDTH-1:0]         num_den,
	output logic [segint_pkg::NUMP_WIDTH-1:0]        prod_x,
	output logic [segint_pkg::NUMP_WIDTH-1:0]        prod_y
);
	import segint_pkg::*;

	localparam int unsigned LO_WIDTH = (MAG_WIDTH + 1) / 2;
	localparam int unsigned HI_WIDTH = MAG_WIDTH - LO_WIDTH;

	logic                          valid_s4, valid_s5, valid_s6;
	side_t                         side_c, side_s4, side_s5, side_s6;
	logic signed [DET_WIDTH-1:0]   den_n, tn_n, un_n;
	logic                          pass_c;
	logic [MAG_WIDTH-1:0]          den_s4, den_s5, den_s6, tn_s4;
	logic [COORD_WIDTH+LO_WIDTH-1:0] plx_s5, ply_s5;
	logic [COORD_WIDTH+HI_WIDTH-1:0] phx_s5, phy_s5;
	logic [NUMP_WIDTH-1:0]         prodx_s6, prody_s6;

	// Normalize to a positive den and pick the result kind
	always_comb begin
		if (det_den[DET_WIDTH-1]) begin
			den_n = -det_den;
			tn_n  = -det_tn;
			un_n  = -det_un;
		end else begin
			den_n = det_den;
			tn_n  = det_tn;
			un_n  = det_un;
		end
		pass_c = (den_n != '0) && !tn_n[DET_WIDTH-1] && !un_n[DET_WIDTH-1] &&
			(tn_n <= den_n) && (un_n <= den_n);

		side_c = det_side;
		if (det_side.ep_start) begin
			side_c.kind = KIND_FIRST_START;
		end else if (det_side.ep_end) begin
			side_c.kind = KIND_FIRST_END;
		end else if (pass_c) begin
			side_c.kind = KIND_CROSS;
		end else begin
			side_c.kind = KIND_NONE;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= det_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 4: test; stage 5: half products; stage 6: combine halves
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_c;
			den_s4  <= den_n[MAG_WIDTH-1:0];
			tn_s4   <= tn_n[MAG_WIDTH-1:0];

			side_s5 <= side_s4;
			den_s5  <= den_s4;
			plx_s5  <= (COORD_WIDTH+LO_WIDTH)'(side_s4.mag_x) *
				(COORD_WIDTH+LO_WIDTH)'(tn_s4[LO_WIDTH-1:0]);
			ply_s5  <= (COORD_WIDTH+LO_WIDTH)'(side_s4.mag_y) *
				(COORD_WIDTH+LO_WIDTH)'(tn_s4[LO_WIDTH-1:0]);
			phx_s5  <= (COORD_WIDTH+HI_WIDTH)'(side_s4.mag_x) *
				(COORD_WIDTH+HI_WIDTH)'(tn_s4[MAG_WIDTH-1:LO_WIDTH]);
			phy_s5  <= (COORD_WIDTH+HI_WIDTH)'(side_s4.mag_y) *
				(COORD_WIDTH+HI_WIDTH)'(tn_s4[MAG_WIDTH-1:LO_WIDTH]);

			side_s6  <= side_s5;
			den_s6   <= den_s5;
			prodx_s6 <= (NUMP_WIDTH'(phx_s5) << LO_WIDTH) + NUMP_WIDTH'(plx_s5);
			prody_s6 <= (NUMP_WIDTH'(phy_s5) << LO_WIDTH) + NUMP_WIDTH'(ply_s5);
		end
	end

	assign num_valid = valid_s6;
	assign num_side  = side_s6;
	assign num_den   = den_s6;
	assign prod_x    = prodx_s6;
	assign prod_y    = prody_s6;

endmodule

[rtl/segint_div.sv]
// ---------------------------------------------------------------------------
// Segment intersection divider pipeline
// Restoring division, one quotient bit per stage, x and y lanes sharing den.
// ---------------------------------------------------------------------------
module segint_div #(
	parameter int unsigned FRAC_BITS = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic                                          num_valid,
	input  segint_pkg::side_t                             num_side,
	input  logic [segint_pkg::MAG_WIDTH-1:0]              num_den,
	input  logic [segint_pkg::NUMP_WIDTH-1:0]             prod_x,
	input  logic [segint_pkg::NUMP_WIDTH-1:0]             prod_y,
	output logic                                          quo_valid,
	output segint_pkg::side_t                             quo_side,
	output logic [segint_pkg::COORD_WIDTH+FRAC_BITS-1:0]  quo_x,
	output logic [segint_pkg::COORD_WIDTH+FRAC_BITS-1:0]  quo_y
);
	import segint_pkg::*;

	localparam int unsigned QW = COORD_WIDTH + FRAC_BITS;
	localparam int unsigned NW = NUMP_WIDTH + FRAC_BITS;

	// One restoring step: shift in a bit, subtract den when it fits
	function automatic logic [MAG_WIDTH:0] div_step(
		input logic [MAG_WIDTH-1:0] rem,
		input logic [MAG_WIDTH-1:0] dvs,
		input logic                 nb
	);
		logic [MAG_WIDTH:0] sh;
		logic [MAG_WIDTH:0] df;
		sh = {rem, nb};
		df = sh - {1'b0, dvs};
		if (sh >= {1'b0, dvs}) begin
			div_step = {1'b1, df[MAG_WIDTH-1:0]};
		end else begin
			div_step = {1'b0, sh[MAG_WIDTH-1:0]};
		end
	endfunction

	logic [NW-1:0]        numx, numy;
	logic                 valid_s [QW];
	side_t                side_s  [QW];
	logic [MAG_WIDTH-1:0] den_s   [QW];
	logic [MAG_WIDTH-1:0] remx_s  [QW];
	logic [MAG_WIDTH-1:0] remy_s  [QW];
	logic [QW-1:0]        bitx_s  [QW];
	logic [QW-1:0]        bity_s  [QW];

	// Scale numerators by the fraction bits
	assign numx = NW'(prod_x) << FRAC_BITS;
	assign numy = NW'(prod_y) << FRAC_BITS;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                 valid_in;
		side_t                side_in;
		logic [MAG_WIDTH-1:0] den_in, remx_in, remy_in;
		logic [QW-1:0]        bitx_in, bity_in;
		logic [MAG_WIDTH:0]   stepx, stepy;

		// Take the numerator split or the previous stage
		if (k == 0) begin : g_first
			assign valid_in = num_valid;
			assign side_in  = num_side;
			assign den_in   = num_den;
			assign remx_in  = numx[NW-1:QW];
			assign remy_in  = numy[NW-1:QW];
			assign bitx_in  = numx[QW-1:0];
			assign bity_in  = numy[QW-1:0];
		end else begin : g_next
			assign valid_in = valid_s[k-1];
			assign side_in  = side_s[k-1];
			assign den_in   = den_s[k-1];
			assign remx_in  = remx_s[k-1];
			assign remy_in  = remy_s[k-1];
			assign bitx_in  = bitx_s[k-1];
			assign bity_in  = bity_s[k-1];
		end

		assign stepx = div_step(remx_in, den_in, bitx_in[QW-1]);
		assign stepy = div_step(remy_in, den_in, bity_in[QW-1]);

		// Advance valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_in;
			end
		end

		// Shift quotient bit in, keep the partial remainder
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_in;
				den_s[k]  <= den_in;
				remx_s[k] <= stepx[MAG_WIDTH-1:0];
				remy_s[k] <= stepy[MAG_WIDTH-1:0];
				bitx_s[k] <= {bitx_in[QW-2:0], stepx[MAG_WIDTH]};
				bity_s[k] <= {bity_in[QW-2:0], stepy[MAG_WIDTH]};
			end
		end
	end

	assign quo_valid = valid_s[QW-1];
	assign quo_side  = side_s[QW-1];
	assign quo_x     = bitx_s[QW-1];
	assign quo_y     = bity_s[QW-1];

endmodule

[rtl/segment_intersection.sv]
// ---------------------------------------------------------------------------
// Segment intersection
// Pipeline: determinant, range test and numerator, divider and output stages.
// Throughput: one segment pair per cycle while the output is not stalled. The
// divider retires one quotient bit per stage, so its depth sets the latency.
// Reset clears every valid bit at once; data registers are not reset.
// ---------------------------------------------------------------------------
`include "segment_intersection_assert.svh"

module segment_intersection #(
	parameter int unsigned FRAC_BITS = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  seg_valid,
	output logic                  seg_stall,
	input  segint_pkg::seg_t      seg,
	output logic                  result_valid,
	input  logic                  result_stall,
	output segint_pkg::result_t   result
);
	import segint_pkg::*;

	localparam int unsigned QW   = COORD_WIDTH + FRAC_BITS;
	localparam int unsigned SUMW = (QW > OUT_WIDTH) ? QW : OUT_WIDTH;

	// Place a point: base scaled by the fraction bits, plus or minus an offset
	function automatic logic [OUT_WIDTH-1:0] place(
		input coord_t        base,
		input logic [QW-1:0] ofs,
		input logic          sub
	);
		logic [SUMW-1:0] b;
		logic [SUMW-1:0] r;
		b = SUMW'(base) << FRAC_BITS;
		r = sub ? (b - SUMW'(ofs)) : (b + SUMW'(ofs));
		place = r[OUT_WIDTH-1:0];
	endfunction

	logic                        adv;
	logic                        det_valid, num_valid, div_valid;
	side_t                       det_side, num_side, div_side;
	logic signed [DET_WIDTH-1:0] det_den, det_tn, det_un;
	logic [MAG_WIDTH-1:0]        num_den;
	logic [NUMP_WIDTH-1:0]       prod_x, prod_y;
	logic [QW-1:0]               div_quo_x, div_quo_y;
	result_t                     res_c, result_q;
	logic                        result_valid_q;
	logic                        res_point_zero, div_cross, quo_in_range;

	// Hold the whole pipeline only while a finished result is refused
	assign adv       = !(result_valid_q && result_stall);
	assign seg_stall = !adv;

	segint_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.seg_valid (seg_valid),
		.seg       (seg),
		.det_valid (det_valid),
		.det_side  (det_side),
		.det_den   (det_den),
		.det_tn    (det_tn),
		.det_un    (det_un)
	);

	segint_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.det_valid (det_valid),
		.det_side  (det_side),
		.det_den   (det_den),
		.det_tn    (det_tn),
		.det_un    (det_un),
		.num_valid (num_valid),
		.num_side  (num_side),
		.num_den   (num_den),
		.prod_x    (prod_x),
		.prod_y    (prod_y)
	);

	segint_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.num_valid (num_valid),
		.num_side  (num_side),
		.num_den   (num_den),
		.prod_x    (prod_x),
		.prod_y    (prod_y),
		.quo_valid (div_valid),
		.quo_side  (div_side),
		.quo_x     (div_quo_x),
		.quo_y     (div_quo_y)
	);

	// Build the result point from its kind
	always_comb begin
		case (div_side.kind)
			KIND_FIRST_START: begin
				res_c.hit     = 1'b1;
				res_c.cross_x = place(div_side.x1, '0, 1'b0);
				res_c.cross_y = place(div_side.y1, '0, 1'b0);
			end
			KIND_FIRST_END: begin
				res_c.hit     = 1'b1;
				res_c.cross_x = place(div_side.x2, '0, 1'b0);
				res_c.cross_y = place(div_side.y2, '0, 1'b0);
			end
			KIND_CROSS: begin
				res_c.hit     = 1'b1;
				res_c.cross_x = place(div_side.x1, div_quo_x, div_side.sub_x);
				res_c.cross_y = place(div_side.y1, div_quo_y, div_side.sub_y);
			end
			default: begin
				res_c.hit     = 1'b0;
				res_c.cross_x = '0;
				res_c.cross_y = '0;
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= div_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Terms for the checks below
	assign res_point_zero = (result.cross_x == '0) && (result.cross_y == '0);
	assign div_cross      = div_valid && (div_side.kind == KIND_CROSS);
	assign quo_in_range   = (div_quo_x <= (QW'(div_side.mag_x) << FRAC_BITS)) &&
		(div_quo_y <= (QW'(div_side.mag_y) << FRAC_BITS));

	`SEGINT_ASSERT(a_miss_is_zero, (result_valid && !result.hit) |-> res_point_zero, "miss with point")
	`SEGINT_ASSERT_NEXT(a_div_to_out, div_valid && adv, result_valid, "divider transaction lost")
	`SEGINT_ASSERT(a_quo_bound, div_cross |-> quo_in_range, "quotient beyond segment")

endmodule
